[sv/mss_pkg.sv]
package mss_pkg;

    localparam int MAX_ROWS_DEF   = 32;
    localparam int MAX_COLS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 16;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    localparam int ELEMENT_W = 16;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 5;
    localparam int SUM_W     = 32;
    localparam int OUT_CNT_W = 11;

    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clear;
    } col_ctl_t;

endpackage

[sv/mss_elem_if.sv]
interface mss_elem_if;
    import mss_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [ELEMENT_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);

endinterface

[sv/mss_result_if.sv]
interface mss_result_if;
    import mss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       result_kind;
    logic [POS_W-1:0]        position;
    logic signed [SUM_W-1:0] sum_value;
    logic [OUT_CNT_W-1:0]    prime_count;
    logic [OUT_CNT_W-1:0]    even_count;
    logic [OUT_CNT_W-1:0]    odd_count;
    logic                    last;

    modport source (
        output valid, output result_kind, output position, output sum_value,
        output prime_count, output even_count, output odd_count, output last,
        input ready
    );
    modport sink (
        input valid, input result_kind, input position, input sum_value,
        input prime_count, input even_count, input odd_count, input last,
        output ready
    );

endinterface

[sv/mss_prime_unit.sv]
module mss_prime_unit #(
    parameter int VALUE_BITS = mss_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  done,
    output logic                  is_prime
);
    import mss_pkg::*;

    localparam int U_W   = VALUE_BITS - 1;
    localparam int DIV_W = (VALUE_BITS < 4) ? 2 : (VALUE_BITS + 1) / 2;
    localparam int K     = U_W + DIV_W;
    localparam int P_W   = U_W + K;
    localparam int Q_W   = U_W + DIV_W;
    localparam int SQ_W  = 2 * DIV_W;

    logic [K-1:0] recip_tab [2**DIV_W];

    for (genvar g = 0; g < 2**DIV_W; g++)
    begin : g_recip
        localparam int DEN   = (g < 2) ? 2 : g;
        localparam int RECIP = ((1 << K) + DEN - 1) / DEN;
        assign recip_tab[g] = K'(RECIP);
    end

    logic             busy_reg, busy_next;
    logic             small_reg, small_next;
    logic [U_W-1:0]   u_reg, u_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic             s1_vld_reg, s1_vld_next;
    logic [DIV_W-1:0] s1_d_reg, s1_d_next;
    logic [P_W-1:0]   s1_prod_reg, s1_prod_next;
    logic [SQ_W-1:0]  s1_sq_reg, s1_sq_next;
    logic             s2_vld_reg, s2_vld_next;
    logic [Q_W-1:0]   s2_qd_reg, s2_qd_next;
    logic [SQ_W-1:0]  s2_sq_reg, s2_sq_next;

    logic           small_in;
    logic [U_W-1:0] quot;
    logic           sq_over;
    logic           divisible;
    logic           term;

    assign small_in  = value[VALUE_BITS-1] || (32'(value[U_W-1:0]) < 32'd2);
    assign quot      = s1_prod_reg[P_W-1:K];
    assign sq_over   = s2_sq_reg > SQ_W'(u_reg);
    assign divisible = s2_qd_reg == Q_W'(u_reg);
    assign term      = s2_vld_reg && (sq_over || divisible);
    assign done      = small_reg || term;
    assign is_prime  = !small_reg && sq_over;

    always_comb
    begin
        busy_next    = busy_reg;
        small_next   = 1'b0;
        u_next       = u_reg;
        d_next       = d_reg;
        s1_vld_next  = 1'b0;
        s1_d_next    = d_reg;
        s1_prod_next = P_W'(u_reg) * P_W'(recip_tab[d_reg]);
        s1_sq_next   = SQ_W'(d_reg) * SQ_W'(d_reg);
        s2_vld_next  = s1_vld_reg;
        s2_qd_next   = Q_W'(quot) * Q_W'(s1_d_reg);
        s2_sq_next   = s1_sq_reg;
        if (start)
        begin
            busy_next   = !small_in;
            small_next  = small_in;
            u_next      = value[U_W-1:0];
            d_next      = DIV_W'(2);
            s2_vld_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (term)
            begin
                busy_next   = 1'b0;
                s2_vld_next = 1'b0;
            end
            else
            begin
                s1_vld_next = 1'b1;
                d_next      = d_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            small_reg  <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            small_reg  <= small_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg       <= u_next;
        d_reg       <= d_next;
        s1_d_reg    <= s1_d_next;
        s1_prod_reg <= s1_prod_next;
        s1_sq_reg   <= s1_sq_next;
        s2_qd_reg   <= s2_qd_next;
        s2_sq_reg   <= s2_sq_next;
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("prime test started while busy");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> busy_reg)
        else $error("divisor result outside a test");

    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_prime) |-> (32'(u_reg) >= 32'd2))
        else $error("value below two reported prime");
`endif

endmodule

[sv/mss_col_store.sv]
module mss_col_store #(
    parameter int DEPTH  = mss_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 21
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mss_pkg::col_ctl_t        ctl,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [DATA_W-1:0] rd_data,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [DATA_W-1:0] wr_data
);
    import mss_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

endmodule

[sv/matrix_stream_statistics.sv]
// Matrix row/column sums with prime count. Elements enter one item at a time in row-major
// order; row_count and col_count (config index 0 and 1, 0 acts as 1, values above the
// maximum clamp) set the shape. Each row end emits a row-sum item; after the last element
// the block emits one column-sum item per column and a final item with the grand total
// and the prime, even and odd counts, with last set. Each element is tested for primality
// by trial division through a two-stage reciprocal-multiply pipeline that tries one
// divisor per cycle, so an element of value v >= 2 occupies the block until a divisor
// divides it or the square of the divisor exceeds v; values below 2 skip the search.
// A row end and the matrix end pass through further states that wait for a free output
// register, the matrix end reading each column in turn from the column-sum memory.
// Results sit in an output register, so the next element is taken while the final
// result still waits downstream.
module matrix_stream_statistics #(
    parameter int MAX_ROWS   = mss_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = mss_pkg::MAX_COLS_DEF,
    parameter int VALUE_BITS = mss_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_W-1:0]      cfg_data,
    mss_elem_if.sink                       elem,
    mss_result_if.source                   result
);
    import mss_pkg::*;

    localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = VALUE_BITS + $clog2(MAX_COLS);
    localparam int COL_W = VALUE_BITS + $clog2(MAX_ROWS);
    localparam int TOT_W = VALUE_BITS + $clog2(MAX_ROWS * MAX_COLS);
    localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int CMP_W = CFG_W + 1;

    localparam int S_W = 3;
    localparam logic [S_W-1:0] S_IDLE   = 3'd0;
    localparam logic [S_W-1:0] S_WAIT   = 3'd1;
    localparam logic [S_W-1:0] S_ROW    = 3'd2;
    localparam logic [S_W-1:0] S_COLRD  = 3'd3;
    localparam logic [S_W-1:0] S_COLOUT = 3'd4;
    localparam logic [S_W-1:0] S_FINAL  = 3'd5;

    logic [CFG_W-1:0] row_cfg_reg;
    logic [CFG_W-1:0] col_cfg_reg;
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;

    logic [S_W-1:0]               state_reg, state_next;
    logic signed [VALUE_BITS-1:0] v_reg, v_next;
    logic [RI_W-1:0]              row_idx_reg, row_idx_next;
    logic [CI_W-1:0]              col_idx_reg, col_idx_next;
    logic [CI_W-1:0]              col_j_reg, col_j_next;
    logic signed [ROW_W-1:0]      row_sum_reg, row_sum_next;
    logic signed [TOT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]             prime_cnt_reg, prime_cnt_next;
    logic [CNT_W-1:0]             even_cnt_reg, even_cnt_next;
    logic [CNT_W-1:0]             odd_cnt_reg, odd_cnt_next;

    logic                    out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]       out_kind_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic [OUT_CNT_W-1:0]    out_pc_reg;
    logic [OUT_CNT_W-1:0]    out_ec_reg;
    logic [OUT_CNT_W-1:0]    out_oc_reg;
    logic                    out_last_reg;

    logic                    out_load;
    logic [KIND_W-1:0]       ld_kind;
    logic [POS_W-1:0]        ld_pos;
    logic signed [SUM_W-1:0] ld_sum;
    logic [OUT_CNT_W-1:0]    ld_pc;
    logic [OUT_CNT_W-1:0]    ld_ec;
    logic [OUT_CNT_W-1:0]    ld_oc;
    logic                    ld_last;

    logic                    slot_free;
    logic                    col_last;
    logic                    row_last;
    logic                    sweep_last;
    logic                    elem_ready;
    logic                    prm_start;
    logic                    prm_done;
    logic                    prm_is_prime;
    col_ctl_t                col_ctl;
    logic [CI_W-1:0]         col_addr;
    logic signed [COL_W-1:0] col_rd_data;
    logic signed [COL_W-1:0] col_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= CFG_W'(1);
            col_cfg_reg <= CFG_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ROW_COUNT: row_cfg_reg <= cfg_data;
                REG_COL_COUNT: col_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (row_cfg_reg == '0)
        begin
            rows_eff = CFG_W'(1);
        end
        else if (row_cfg_reg > CFG_W'(MAX_ROWS))
        begin
            rows_eff = CFG_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = row_cfg_reg;
        end
        if (col_cfg_reg == '0)
        begin
            cols_eff = CFG_W'(1);
        end
        else if (col_cfg_reg > CFG_W'(MAX_COLS))
        begin
            cols_eff = CFG_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = col_cfg_reg;
        end
    end

    assign col_last   = !(CMP_W'(col_idx_reg) + CMP_W'(1) < CMP_W'(cols_eff));
    assign row_last   = !(CMP_W'(row_idx_reg) + CMP_W'(1) < CMP_W'(rows_eff));
    assign sweep_last = !(CMP_W'(col_j_reg) + CMP_W'(1) < CMP_W'(cols_eff));
    assign slot_free  = !out_valid_reg || result.ready;
    assign col_wdata  = col_rd_data + COL_W'(v_reg);

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        row_idx_next   = row_idx_reg;
        col_idx_next   = col_idx_reg;
        col_j_next     = col_j_reg;
        row_sum_next   = row_sum_reg;
        total_next     = total_reg;
        prime_cnt_next = prime_cnt_reg;
        even_cnt_next  = even_cnt_reg;
        odd_cnt_next   = odd_cnt_reg;
        elem_ready     = 1'b0;
        prm_start      = 1'b0;
        col_ctl        = '0;
        col_addr       = col_idx_reg;
        out_load       = 1'b0;
        ld_kind        = KIND_ROW;
        ld_pos         = '0;
        ld_sum         = '0;
        ld_pc          = '0;
        ld_ec          = '0;
        ld_oc          = '0;
        ld_last        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                elem_ready = 1'b1;
                if (elem.valid)
                begin
                    v_next      = elem.element_value[VALUE_BITS-1:0];
                    prm_start   = 1'b1;
                    col_ctl.rd  = 1'b1;
                    state_next  = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (prm_done)
                begin
                    col_ctl.wr   = 1'b1;
                    row_sum_next = row_sum_reg + ROW_W'(v_reg);
                    total_next   = total_reg + TOT_W'(v_reg);
                    if (prm_is_prime)
                    begin
                        prime_cnt_next = prime_cnt_reg + 1'b1;
                    end
                    if (v_reg[0])
                    begin
                        odd_cnt_next = odd_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        even_cnt_next = even_cnt_reg + 1'b1;
                    end
                    if (col_last)
                    begin
                        col_idx_next = '0;
                        state_next   = S_ROW;
                    end
                    else
                    begin
                        col_idx_next = col_idx_reg + 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_ROW:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    ld_kind      = KIND_ROW;
                    ld_pos       = POS_W'(row_idx_reg);
                    ld_sum       = SUM_W'(row_sum_reg);
                    row_sum_next = '0;
                    if (row_last)
                    begin
                        col_j_next = '0;
                        state_next = S_COLRD;
                    end
                    else
                    begin
                        row_idx_next = row_idx_reg + 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_COLRD:
            begin
                col_ctl.rd = 1'b1;
                col_addr   = col_j_reg;
                state_next = S_COLOUT;
            end
            S_COLOUT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    ld_kind  = KIND_COL;
                    ld_pos   = POS_W'(col_j_reg);
                    ld_sum   = SUM_W'(col_rd_data);
                    if (sweep_last)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        col_j_next = col_j_reg + 1'b1;
                        state_next = S_COLRD;
                    end
                end
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    ld_kind        = KIND_TOTAL;
                    ld_sum         = SUM_W'(total_reg);
                    ld_pc          = OUT_CNT_W'(prime_cnt_reg);
                    ld_ec          = OUT_CNT_W'(even_cnt_reg);
                    ld_oc          = OUT_CNT_W'(odd_cnt_reg);
                    ld_last        = 1'b1;
                    total_next     = '0;
                    prime_cnt_next = '0;
                    even_cnt_next  = '0;
                    odd_cnt_next   = '0;
                    row_idx_next   = '0;
                    col_ctl.clear  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            col_j_reg     <= '0;
            row_sum_reg   <= '0;
            total_reg     <= '0;
            prime_cnt_reg <= '0;
            even_cnt_reg  <= '0;
            odd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            col_j_reg     <= col_j_next;
            row_sum_reg   <= row_sum_next;
            total_reg     <= total_next;
            prime_cnt_reg <= prime_cnt_next;
            even_cnt_reg  <= even_cnt_next;
            odd_cnt_reg   <= odd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (out_load)
        begin
            out_kind_reg <= ld_kind;
            out_pos_reg  <= ld_pos;
            out_sum_reg  <= ld_sum;
            out_pc_reg   <= ld_pc;
            out_ec_reg   <= ld_ec;
            out_oc_reg   <= ld_oc;
            out_last_reg <= ld_last;
        end
    end

    assign elem.ready         = elem_ready;
    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.position    = out_pos_reg;
    assign result.sum_value   = out_sum_reg;
    assign result.prime_count = out_pc_reg;
    assign result.even_count  = out_ec_reg;
    assign result.odd_count   = out_oc_reg;
    assign result.last        = out_last_reg;

    mss_prime_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_prime (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (prm_start),
        .value    (elem.element_value[VALUE_BITS-1:0]),
        .done     (prm_done),
        .is_prime (prm_is_prime)
    );

    mss_col_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (CI_W),
        .DATA_W (COL_W)
    ) u_cols (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (col_ctl),
        .rd_addr (col_addr),
        .rd_data (col_rd_data),
        .wr_addr (col_idx_reg),
        .wr_data (col_wdata)
    );

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        prm_done |-> (state_reg == S_WAIT))
        else $error("prime result outside wait state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("output register overwritten");

    a_clear_wr: assert property (@(posedge clk) disable iff (!rst_n)
        col_ctl.clear |-> !col_ctl.wr)
        else $error("column clear and write together");
`endif

endmodule

[tb/sv/matrix_stream_statistics_tb.sv]
module matrix_stream_statistics_tb;
    import mss_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 2000;
    localparam int RANDOM_ITEMS  = 180;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic signed [ELEMENT_W-1:0] value;
        bit                          drain_first;
    } element_item_t;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [POS_W-1:0]     pos;
        logic [SUM_W-1:0]     value;
        logic [OUT_CNT_W-1:0] primes;
        logic [OUT_CNT_W-1:0] evens;
        logic [OUT_CNT_W-1:0] odds;
        logic                 last;
    } stat_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mss_elem_if   elem_ch();
    mss_result_if result_ch();

    matrix_stream_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .elem      (elem_ch),
        .result    (result_ch)
    );

    element_item_t pending_elements[$];
    stat_item_t    stats_due[$];

    bit calm;
    int offered_count;
    int taken_count;
    int send_gap;
    int stall_requests;
    int stalls_served;
    int hold_left;
    int fail_count;
    int cycle_count;

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    longint           col_sums[MAX_COLS_DEF];
    longint           row_total;
    longint           grand_sum;
    int               prime_tally;
    int               even_tally;
    int               odd_tally;
    int               row_at;
    int               col_at;

    function automatic int effective_count(logic [CFG_W-1:0] raw, int maxv);
        if (raw == '0)
            return 1;
        if (int'(raw) > maxv)
            return maxv;
        return int'(raw);
    endfunction

    function automatic bit is_prime_value(int v);
        int d;
        if (v < 2)
            return 0;
        for (d = 2; d * d <= v; d++)
        begin
            if (v % d == 0)
                return 0;
        end
        return 1;
    endfunction

    function automatic void push_stat(logic [KIND_W-1:0] kind, int pos, longint value,
                                      int primes, int evens, int odds, logic last);
        stat_item_t s;
        s.kind   = kind;
        s.pos    = POS_W'(pos);
        s.value  = SUM_W'(value);
        s.primes = OUT_CNT_W'(primes);
        s.evens  = OUT_CNT_W'(evens);
        s.odds   = OUT_CNT_W'(odds);
        s.last   = last;
        stats_due.push_back(s);
    endfunction

    function automatic void clear_matrix();
        foreach (col_sums[j])
            col_sums[j] = 0;
        row_total   = 0;
        grand_sum   = 0;
        prime_tally = 0;
        even_tally  = 0;
        odd_tally   = 0;
        row_at      = 0;
        col_at      = 0;
    endfunction

    function automatic void tally_element(logic signed [ELEMENT_W-1:0] elem_val);
        int v;
        int rows_eff;
        int cols_eff;
        rows_eff = effective_count(rows_reg, MAX_ROWS_DEF);
        cols_eff = effective_count(cols_reg, MAX_COLS_DEF);
        v = int'(elem_val);
        col_sums[col_at] += v;
        row_total += v;
        grand_sum += v;
        if (is_prime_value(v))
            prime_tally++;
        if (elem_val[0])
            odd_tally++;
        else
            even_tally++;
        if (col_at + 1 < cols_eff)
        begin
            col_at++;
            return;
        end
        push_stat(KIND_ROW, row_at, row_total, 0, 0, 0, 1'b0);
        row_total = 0;
        col_at    = 0;
        if (row_at + 1 < rows_eff)
        begin
            row_at++;
            return;
        end
        for (int j = 0; j < cols_eff; j++)
            push_stat(KIND_COL, j, col_sums[j], 0, 0, 0, 1'b0);
        push_stat(KIND_TOTAL, 0, grand_sum, prime_tally, even_tally, odd_tally, 1'b1);
        clear_matrix();
    endfunction

    function automatic void push_element(logic signed [ELEMENT_W-1:0] value, bit drain_first);
        element_item_t e;
        e.value       = value;
        e.drain_first = drain_first;
        pending_elements.push_back(e);
    endfunction

    function automatic logic signed [ELEMENT_W-1:0] draw_element();
        case ($urandom_range(0, 4))
            0: return ELEMENT_W'($urandom_range(0, 60));
            1: return ELEMENT_W'(-int'($urandom_range(0, 60)));
            2: return ELEMENT_W'($urandom_range(32000, 32767));
            default: return ELEMENT_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic write_shape(logic [CFG_W-1:0] rows_raw, logic [CFG_W-1:0] cols_raw);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_ROW_COUNT, rows_raw);
            write_reg(REG_COL_COUNT, cols_raw);
        end
        else
        begin
            write_reg(REG_COL_COUNT, cols_raw);
            write_reg(REG_ROW_COUNT, rows_raw);
        end
    endtask

    task automatic settle();
        while (pending_elements.size() != 0 || elem_ch.valid || stats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL matrix_stream_statistics");
            $finish;
        end
    end

    // element driver
    always @(negedge clk)
    begin
        element_item_t next_item;
        if (!rst_n)
        begin
            elem_ch.valid         <= 1'b0;
            elem_ch.element_value <= '0;
        end
        else if (elem_ch.valid && taken_count != offered_count)
        begin
            // hold until taken
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            elem_ch.valid <= 1'b0;
        end
        else if (pending_elements.size() == 0)
        begin
            elem_ch.valid <= 1'b0;
        end
        else if (pending_elements[0].drain_first && stats_due.size() != 0)
        begin
            elem_ch.valid <= 1'b0;
        end
        else
        begin
            next_item = pending_elements.pop_front();
            elem_ch.element_value <= next_item.value;
            elem_ch.valid         <= 1'b1;
            offered_count++;
            if (!calm && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 7);
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (stalls_served != stall_requests)
        begin
            stalls_served   = stall_requests;
            hold_left       = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            hold_left       = $urandom_range(0, 6);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // monitor and prediction
    always @(posedge clk)
    begin
        stat_item_t want;
        stat_item_t got;
        if (!rst_n)
        begin
            rows_reg = CFG_W'(1);
            cols_reg = CFG_W'(1);
            clear_matrix();
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.kind   = result_ch.result_kind;
                got.pos    = result_ch.position;
                got.value  = result_ch.sum_value;
                got.primes = result_ch.prime_count;
                got.evens  = result_ch.even_count;
                got.odds   = result_ch.odd_count;
                got.last   = result_ch.last;
                if (stats_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: kind %0d pos %0d sum %0d last %0b",
                                 got.kind, got.pos, $signed(got.value), got.last);
                end
                else
                begin
                    want = stats_due.pop_front();
                    if (got.kind !== want.kind || got.pos !== want.pos
                        || got.value !== want.value || got.primes !== want.primes
                        || got.evens !== want.evens || got.odds !== want.odds
                        || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected kind %0d pos %0d sum %0d ",
                                      "primes %0d evens %0d odds %0d last %0b, got kind %0d ",
                                      "pos %0d sum %0d primes %0d evens %0d odds %0d last %0b"},
                                     want.kind, want.pos, $signed(want.value), want.primes,
                                     want.evens, want.odds, want.last, got.kind, got.pos,
                                     $signed(got.value), got.primes, got.evens, got.odds,
                                     got.last);
                    end
                end
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_ROW_COUNT: rows_reg = cfg_data;
                    REG_COL_COUNT: cols_reg = cfg_data;
                    default: ;
                endcase
            end
            if (elem_ch.valid && elem_ch.ready)
            begin
                taken_count++;
                tally_element(elem_ch.element_value);
            end
        end
    end

    initial
    begin
        int rand_sent;
        int phase;
        int n;
        int rows_eff;
        int cols_eff;
        logic [CFG_W-1:0] rows_raw;
        logic [CFG_W-1:0] cols_raw;

        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = REG_ROW_COUNT;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_element(16'sd0, 1'b0);
        push_element(16'sd1, 1'b0);
        push_element(16'sd2, 1'b0);
        push_element(16'sd3, 1'b0);
        settle();

        // zero counts act as one
        write_shape(CFG_W'(0), CFG_W'(0));
        push_element(16'sd32767, 1'b0);
        push_element(16'sh8000, 1'b0);
        push_element(-16'sd1, 1'b0);
        push_element(-16'sd7, 1'b0);
        push_element(16'sd4, 1'b0);
        push_element(16'sd25, 1'b0);
        push_element(16'sd32749, 1'b0);
        push_element(16'sd32761, 1'b0);
        settle();

        write_shape(CFG_W'(2), CFG_W'(2));
        push_element(16'sd32767, 1'b0);
        push_element(16'sd32767, 1'b0);
        push_element(16'sh8000, 1'b0);
        push_element(16'sh8000, 1'b0);
        settle();

        // shrink the column count mid-row, then the row count mid-matrix
        write_shape(CFG_W'(2), CFG_W'(3));
        push_element(16'sd5, 1'b0);
        push_element(16'sd6, 1'b0);
        settle();
        write_reg(REG_COL_COUNT, CFG_W'(1));
        push_element(16'sd7, 1'b0);
        push_element(-16'sd9, 1'b0);
        settle();
        write_shape(CFG_W'(3), CFG_W'(1));
        push_element(16'sd11, 1'b0);
        push_element(16'sd12, 1'b0);
        settle();
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        push_element(16'sd13, 1'b0);
        settle();

        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (rand_sent >= RANDOM_ITEMS - 45)
                calm = 1'b1;
            case (phase)
                0:
                begin
                    rows_raw = CFG_W'(63);
                    cols_raw = CFG_W'(1);
                end
                1:
                begin
                    rows_raw = CFG_W'(1);
                    cols_raw = CFG_W'(63);
                end
                2:
                begin
                    rows_raw = CFG_W'(1);
                    cols_raw = CFG_W'(32);
                end
                default:
                begin
                    rows_raw = CFG_W'($urandom_range(1, 6));
                    cols_raw = CFG_W'($urandom_range(1, 6));
                    if ($urandom_range(0, 5) == 0)
                        rows_raw = $urandom_range(0, 1) ? CFG_W'(0)
                                                        : CFG_W'($urandom_range(33, 63));
                    if ($urandom_range(0, 5) == 0)
                        cols_raw = $urandom_range(0, 1) ? CFG_W'(0)
                                                        : CFG_W'($urandom_range(33, 63));
                end
            endcase
            rows_eff = effective_count(rows_raw, MAX_ROWS_DEF);
            cols_eff = effective_count(cols_raw, MAX_COLS_DEF);
            settle();
            write_shape(rows_raw, cols_raw);
            if (rows_eff * cols_eff > 16)
            begin
                n = rows_eff * cols_eff;
                if (n > 32)
                    n = 32;
            end
            else
            begin
                n = rows_eff * cols_eff * int'($urandom_range(1, 2));
                if ($urandom_range(0, 3) == 0)
                    n = int'($urandom_range(1, n + 3));
            end
            if (phase == 0)
                stall_requests++;
            for (int i = 0; i < n; i++)
                push_element(draw_element(), $urandom_range(0, 29) == 0);
            rand_sent += n;
            phase++;
        end

        settle();
        if (stats_due.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("PASS matrix_stream_statistics");
        else
            $display("FAIL matrix_stream_statistics");
        $finish;
    end

endmodule
